// ===== hw/rtl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared widths, register codes and the scaling remainder table for the
// barometric pressure and temperature compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

	localparam int QFRAC       = 24;
	localparam int RAW_W       = 24;
	localparam int SCALE_W     = 30;
	localparam int SCALE_SH    = 11;
	localparam int SCALE_MUL   = 2 ** SCALE_SH;
	localparam int SCALE_DIV   = 63;
	localparam int SCALE_RECIP = 17043522;
	localparam int RECIP_SHIFT = 30;
	localparam int RECIP_W     = 25;
	localparam int QUO_W       = 18;
	localparam int REM_W       = 6;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 40;
	localparam int TCAL_W     = 24;
	localparam int PCAL_W     = 40;
	localparam int COEF_W     = 16;
	localparam int TCOEF_W    = 12;
	localparam int PCOEF_W    = 20;

	localparam int TOUT_W = 24;
	localparam int POUT_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_TCAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PCAL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_C01  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_C11  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_C20  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_C21  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_C30  = 3'd6;

	typedef logic [SCALE_SH-1:0] frac_tbl_t [2 ** REM_W];

	// rounded fraction part of 2048 * r / 63 for each remainder r
	function automatic frac_tbl_t frac_table();
		frac_tbl_t t;
		for (int i = 0; i < 2 ** REM_W; i++) begin
			t[i] = SCALE_SH'((SCALE_MUL * i + (SCALE_DIV - 1) / 2) / SCALE_DIV);
		end
		return t;
	endfunction

	localparam frac_tbl_t FRAC_TBL = frac_table();

endpackage

// ===== hw/rtl/bpc_scale.sv =====
// ----------------------------------------------------------------------------
// bpc_scale
// Two-stage scaling of a raw signed sample by 2048/63 with rounding to
// nearest, through a reciprocal multiply and a remainder table.
// ----------------------------------------------------------------------------
module bpc_scale (
	input  logic                               clk,
	input  logic signed [bpc_pkg::RAW_W-1:0]   raw,
	output logic signed [bpc_pkg::SCALE_W-1:0] scaled
);
	import bpc_pkg::*;

	localparam int PROD_W = RAW_W + RECIP_W;
	localparam int Q_W    = QUO_W + SCALE_SH;

	logic [RAW_W-1:0]  mag;
	logic [PROD_W-1:0] prod;
	logic [RAW_W-1:0]  mag_s1;
	logic [QUO_W-1:0]  quo_s1;
	logic              neg_s1;
	logic [RAW_W-1:0]  rem_full;
	logic [REM_W-1:0]  rem;
	logic [Q_W-1:0]    q;

	assign mag  = raw[RAW_W-1] ? RAW_W'(-raw) : RAW_W'(raw);
	assign prod = PROD_W'(mag) * PROD_W'(SCALE_RECIP);

	always_ff @(posedge clk) begin
		mag_s1 <= mag;
		quo_s1 <= prod[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
		neg_s1 <= raw[RAW_W-1];
	end

	assign rem_full = mag_s1 - RAW_W'(quo_s1) * RAW_W'(SCALE_DIV);
	assign rem      = rem_full[REM_W-1:0];
	assign q        = {quo_s1, {SCALE_SH{1'b0}}} + Q_W'(FRAC_TBL[rem]);

	always_ff @(posedge clk) begin
		scaled <= neg_s1 ? -$signed({1'b0, q}) : $signed({1'b0, q});
	end

endmodule

// ===== hw/rtl/bpc_qmul.sv =====
// ----------------------------------------------------------------------------
// bpc_qmul
// Two-stage signed fixed-point multiply, product rounded back by 24
// fraction bits to nearest with ties away from zero. The second operand is
// split into a low fraction part and a signed high part.
// ----------------------------------------------------------------------------
module bpc_qmul #(
	parameter int WX = 30,
	parameter int WY = 30
) (
	input  logic                    clk,
	input  logic signed [WX-1:0]    x,
	input  logic signed [WY-1:0]    y,
	output logic signed [WX+WY-24:0] p
);
	import bpc_pkg::*;

	localparam int WH   = WY - QFRAC;
	localparam int HI_W = WX + WH;
	localparam int LO_W = WX + QFRAC + 1;
	localparam int WO   = WX + WY - QFRAC + 1;

	localparam logic signed [LO_W-1:0] HALF    = LO_W'(2 ** (QFRAC - 1));
	localparam logic signed [LO_W-1:0] HALF_DN = LO_W'(2 ** (QFRAC - 1) - 1);

	logic signed [WH-1:0]    y_hi;
	logic signed [QFRAC:0]   y_lo;
	logic signed [HI_W-1:0]  hi_s1;
	logic signed [LO_W-1:0]  lo_s1;
	logic                    neg_s1;
	logic signed [LO_W-1:0]  lo_sum;
	logic signed [LO_W-1:0]  lo_sh;

	assign y_hi = y[WY-1:QFRAC];
	assign y_lo = {1'b0, y[QFRAC-1:0]};

	always_ff @(posedge clk) begin
		hi_s1  <= x * y_hi;
		lo_s1  <= x * y_lo;
		neg_s1 <= x[WX-1] ^ y[WY-1];
	end

	assign lo_sum = lo_s1 + (neg_s1 ? HALF_DN : HALF);
	assign lo_sh  = lo_sum >>> QFRAC;

	always_ff @(posedge clk) begin
		p <= WO'(hi_s1) + WO'(lo_sh);
	end

endmodule

// ===== hw/rtl/baro_pressure_temp_compensation.sv =====
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Calibration polynomial for a barometric sensor: scales raw pressure and
// temperature samples and returns compensated, saturated results.
// Throughput: one sample pair per cycle; busy stays low, set by the
// ten-stage multiplier pipeline with no shared unit.
// Reset clears the calibration registers and the stage valid bits.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [bpc_pkg::RAW_W-1:0]     pressure_sample,
	input  logic signed [bpc_pkg::RAW_W-1:0]     raw_temperature,
	output logic                                 done,
	output logic signed [bpc_pkg::TOUT_W-1:0]    temperature_out,
	output logic signed [bpc_pkg::POUT_W-1:0]    pressure_out,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import bpc_pkg::*;

	localparam int LAT     = 10;
	localparam int A_W     = 47;
	localparam int TNUM_W  = 42;
	localparam int TC01_W  = SCALE_W + COEF_W;
	localparam int TPF_W   = 2 * SCALE_W - QFRAC + 1;
	localparam int TP_W    = 34;
	localparam int PA_W    = SCALE_W + A_W - QFRAC + 1;
	localparam int B_W     = 50;
	localparam int CROSS_W = TP_W + A_W - QFRAC + 1;
	localparam int LIN_W   = SCALE_W + B_W - QFRAC + 1;
	localparam int PART_W  = 56;
	localparam int SUM_W   = 58;
	localparam int TEMP_SH = QFRAC - 8;
	localparam int PRES_SH = QFRAC - 6;

	localparam logic signed [TNUM_W-1:0] T_HALF    = TNUM_W'(2 ** (TEMP_SH - 1));
	localparam logic signed [TNUM_W-1:0] T_HALF_DN = TNUM_W'(2 ** (TEMP_SH - 1) - 1);
	localparam logic signed [SUM_W-1:0]  P_HALF    = SUM_W'(2 ** (PRES_SH - 1));
	localparam logic signed [SUM_W-1:0]  P_HALF_DN = SUM_W'(2 ** (PRES_SH - 1) - 1);
	localparam logic signed [TOUT_W-1:0] TOUT_MAX  = {1'b0, {(TOUT_W-1){1'b1}}};
	localparam logic signed [TOUT_W-1:0] TOUT_MIN  = {1'b1, {(TOUT_W-1){1'b0}}};
	localparam logic signed [POUT_W-1:0] POUT_MAX  = {1'b0, {(POUT_W-1){1'b1}}};
	localparam logic signed [POUT_W-1:0] POUT_MIN  = {1'b1, {(POUT_W-1){1'b0}}};

	logic [TCAL_W-1:0]        tcal_q;
	logic [PCAL_W-1:0]        pcal_q;
	logic signed [COEF_W-1:0] c01_q, c11_q, c20_q, c21_q, c30_q;
	logic [LAT-1:0]           valid_q;

	logic signed [TCOEF_W-1:0] c0, c1;
	logic signed [PCOEF_W-1:0] c00, c10;

	logic signed [SCALE_W-1:0] psc_s2, tsc_s2;
	logic signed [SCALE_W-1:0] psc_s3, psc_s4, psc_s5, psc_s6;
	logic signed [A_W-1:0]     a_s3, d_s3, d_s4;
	logic signed [TNUM_W-1:0]  tnum_s3;
	logic signed [TC01_W-1:0]  tc01_s3, tc01_s4, tc01_s5, tc01_s6;
	logic signed [TPF_W-1:0]   tp_s4;
	logic signed [PA_W-1:0]    pa_s5;
	logic signed [B_W-1:0]     b_s6;
	logic signed [CROSS_W-1:0] cross_s6;
	logic signed [PART_W-1:0]  part_s7, part_s8;
	logic signed [LIN_W-1:0]   lin_s8;
	logic signed [SUM_W-1:0]   sum_s9;
	logic signed [TOUT_W-1:0]  tout_s4, tout_s5, tout_s6, tout_s7, tout_s8, tout_s9;
	logic signed [TOUT_W-1:0]  tout_s10;
	logic signed [POUT_W-1:0]  pout_s10;

	logic signed [TC01_W-1:0]  pc30, pc21, tc01;
	logic signed [TNUM_W-1:0]  c1t, tnum_rnd;
	logic signed [SUM_W-1:0]   sum_rnd;
	logic signed [TOUT_W-1:0]  tout_c;
	logic signed [POUT_W-1:0]  pout_c;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign done            = valid_q[LAT-1];
	assign temperature_out = tout_s10;
	assign pressure_out    = pout_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcal_q <= '0;
			pcal_q <= '0;
			c01_q  <= '0;
			c11_q  <= '0;
			c20_q  <= '0;
			c21_q  <= '0;
			c30_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TCAL: tcal_q <= cfg_data[TCAL_W-1:0];
				CFG_PCAL: pcal_q <= cfg_data[PCAL_W-1:0];
				CFG_C01:  c01_q  <= cfg_data[COEF_W-1:0];
				CFG_C11:  c11_q  <= cfg_data[COEF_W-1:0];
				CFG_C20:  c20_q  <= cfg_data[COEF_W-1:0];
				CFG_C21:  c21_q  <= cfg_data[COEF_W-1:0];
				CFG_C30:  c30_q  <= cfg_data[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[LAT-2:0], start && !busy};
		end
	end

	assign c0  = tcal_q[TCAL_W-1:TCOEF_W];
	assign c1  = tcal_q[TCOEF_W-1:0];
	assign c00 = pcal_q[PCAL_W-1:PCOEF_W];
	assign c10 = pcal_q[PCOEF_W-1:0];

	bpc_scale u_scale_p (
		.clk    (clk),
		.raw    (pressure_sample),
		.scaled (psc_s2)
	);

	bpc_scale u_scale_t (
		.clk    (clk),
		.raw    (raw_temperature),
		.scaled (tsc_s2)
	);

	assign pc30 = psc_s2 * c30_q;
	assign pc21 = psc_s2 * c21_q;
	assign tc01 = tsc_s2 * c01_q;
	assign c1t  = tsc_s2 * c1;

	// t * p term
	bpc_qmul #(.WX(SCALE_W), .WY(SCALE_W)) u_qmul_tp (
		.clk (clk),
		.x   (tsc_s2),
		.y   (psc_s2),
		.p   (tp_s4)
	);

	// p * (c20 + p * c30)
	bpc_qmul #(.WX(SCALE_W), .WY(A_W)) u_qmul_pa (
		.clk (clk),
		.x   (psc_s3),
		.y   (a_s3),
		.p   (pa_s5)
	);

	// t * p * (c11 + p * c21)
	bpc_qmul #(.WX(TP_W), .WY(A_W)) u_qmul_cross (
		.clk (clk),
		.x   ($signed(tp_s4[TP_W-1:0])),
		.y   (d_s4),
		.p   (cross_s6)
	);

	// p * (c10 + ...)
	bpc_qmul #(.WX(SCALE_W), .WY(B_W)) u_qmul_lin (
		.clk (clk),
		.x   (psc_s6),
		.y   (b_s6),
		.p   (lin_s8)
	);

	always_comb begin
		tnum_rnd = (tnum_s3 + (tnum_s3[TNUM_W-1] ? T_HALF_DN : T_HALF)) >>> TEMP_SH;
		if (tnum_rnd[TNUM_W-1:TOUT_W-1] == '0 || tnum_rnd[TNUM_W-1:TOUT_W-1] == '1) begin
			tout_c = tnum_rnd[TOUT_W-1:0];
		end else begin
			tout_c = tnum_rnd[TNUM_W-1] ? TOUT_MIN : TOUT_MAX;
		end
	end

	always_comb begin
		sum_rnd = (sum_s9 + (sum_s9[SUM_W-1] ? P_HALF_DN : P_HALF)) >>> PRES_SH;
		if (sum_rnd[SUM_W-1:POUT_W-1] == '0 || sum_rnd[SUM_W-1:POUT_W-1] == '1) begin
			pout_c = sum_rnd[POUT_W-1:0];
		end else begin
			pout_c = sum_rnd[SUM_W-1] ? POUT_MIN : POUT_MAX;
		end
	end

	always_ff @(posedge clk) begin
		psc_s3   <= psc_s2;
		a_s3     <= (A_W'(c20_q) <<< QFRAC) + A_W'(pc30);
		d_s3     <= (A_W'(c11_q) <<< QFRAC) + A_W'(pc21);
		tnum_s3  <= (TNUM_W'(c0) <<< (QFRAC - 1)) + c1t;
		tc01_s3  <= tc01;

		psc_s4   <= psc_s3;
		d_s4     <= d_s3;
		tc01_s4  <= tc01_s3;
		tout_s4  <= tout_c;

		psc_s5   <= psc_s4;
		tc01_s5  <= tc01_s4;
		tout_s5  <= tout_s4;

		psc_s6   <= psc_s5;
		b_s6     <= (B_W'(c10) <<< QFRAC) + B_W'(pa_s5);
		tc01_s6  <= tc01_s5;
		tout_s6  <= tout_s5;

		part_s7  <= (PART_W'(c00) <<< QFRAC) + PART_W'(tc01_s6) + PART_W'(cross_s6);
		tout_s7  <= tout_s6;

		part_s8  <= part_s7;
		tout_s8  <= tout_s7;

		sum_s9   <= SUM_W'(part_s8) + SUM_W'(lin_s8);
		tout_s9  <= tout_s8;

		pout_s10 <= pout_c;
		tout_s10 <= tout_s9;
	end

`ifndef NO_ASSERTIONS
	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("done without a request in flight");

	a_psc_sign: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[1] |-> psc_s2[SCALE_W-1] == $past(pressure_sample[RAW_W-1], 2))
		else $error("scaled pressure sign differs from raw sample");

	a_tsc_sign: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[1] |-> tsc_s2[SCALE_W-1] == $past(raw_temperature[RAW_W-1], 2))
		else $error("scaled temperature sign differs from raw sample");
`endif

endmodule
